// ===== design/vaps_pkg.sv =====
// Shared types, op codes and the sequencer control store for the voice allocator.
package vaps_pkg;

    localparam int VOICE_W = 5;
    localparam int PRIO_W  = 8;
    localparam int MAP_W   = 32;
    localparam int OP_W    = 3;

    localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
    localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
    localparam logic [OP_W-1:0] OP_RETIRE   = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP_ALL = 3'd4;

    typedef struct packed {
        logic        [OP_W-1:0]    op;
        logic signed [PRIO_W-1:0]  req_priority;
        logic        [VOICE_W-1:0] voice_sel;
        logic        [MAP_W-1:0]   ended_mask;
    } item_t;

    typedef struct packed {
        logic               granted;
        logic [VOICE_W-1:0] voice_out;
        logic               stolen;
        logic [MAP_W-1:0]   active_map;
    } result_t;

    // Sequencer steps (control store addresses)
    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_DISPATCH = 2'd1,
        ST_SCAN     = 2'd2,
        ST_FINISH   = 2'd3
    } step_t;

    // Jump conditions: jump to target when true, else fall through to the next step
    typedef enum logic [1:0] {
        C_NO_ACCEPT = 2'd0,
        C_NOT_ALLOC = 2'd1,
        C_NOT_LAST  = 2'd2,
        C_OUT_BUSY  = 2'd3
    } cond_t;

    typedef struct packed {
        cond_t cond;
        step_t target;
        logic  take;    // open the input channel
        logic  misc;    // apply a non-allocate op to the active map
        logic  prime;   // advance the scan address ahead of the first compare
        logic  scan;    // compare one voice, advance the address
        logic  finish;  // commit the grant and load the result register
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = '{cond: C_NO_ACCEPT, target: ST_IDLE, take: 1'b0, misc: 1'b0,
              prime: 1'b0, scan: 1'b0, finish: 1'b0};
        case (step)
            ST_IDLE: begin
                w.cond   = C_NO_ACCEPT;
                w.target = ST_IDLE;
                w.take   = 1'b1;
            end
            ST_DISPATCH: begin
                w.cond   = C_NOT_ALLOC;
                w.target = ST_FINISH;
                w.misc   = 1'b1;
                w.prime  = 1'b1;
            end
            ST_SCAN: begin
                w.cond   = C_NOT_LAST;
                w.target = ST_SCAN;
                w.scan   = 1'b1;
            end
            ST_FINISH: begin
                w.cond   = C_OUT_BUSY;
                w.target = ST_FINISH;
                w.finish = 1'b1;
            end
            default: begin
                w.cond   = C_NO_ACCEPT;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/voice_allocator_priority_steal_unit.sv =====
// Voice allocator with priority stealing, run by a four-step microcoded sequencer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_item : op, req_priority, voice_sel, mask
//  m_      | out       | m_valid / m_ready  | m_item : granted, voice_out, stolen, map
//
//  An allocate's result is registered after dispatch, the scan loop with one priority-memory
//  compare per voice, and finish. The next transaction is taken in idle, after finish.
//  Every other op goes from dispatch straight to finish and registers its result there.
//  Reset (aresetn low, synchronous) clears the active map and the priority valid bits;
//  an entry never written reads as priority zero.
//  A result still waiting on m_ready holds the sequencer in its next finish step with s_ready
//  low, so the next result is not loaded until the result register frees.
module voice_allocator_priority_steal_unit #(
    parameter int NUM_VOICES     = 32,
    parameter int RESERVED_VOICE = 31
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vaps_pkg::item_t   s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output vaps_pkg::result_t m_item
);
    import vaps_pkg::*;

    localparam int IDX_W = $clog2(NUM_VOICES);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(NUM_VOICES - 1);
    localparam logic [VOICE_W-1:0] RSV_IDX  = VOICE_W'(RESERVED_VOICE);
    localparam logic [VOICE_W:0]   NV_LIM   = (VOICE_W + 1)'(NUM_VOICES);

    // Sequencer
    step_t upc_reg, upc_next;
    ctrl_t uc;
    logic  jump;

    // Latched transaction and scan datapath
    item_t                     item_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          pidx_reg;
    logic signed [PRIO_W-1:0]  rdata_reg;
    logic                      rvld_reg;
    logic signed [PRIO_W-1:0]  best_reg;
    logic                      free_found_reg;
    logic [IDX_W-1:0]          free_idx_reg;
    logic                      steal_found_reg;
    logic [IDX_W-1:0]          steal_idx_reg;

    // Voice state
    logic [NUM_VOICES-1:0]     active_reg, active_next;
    logic [NUM_VOICES-1:0]     pvld_reg;
    logic signed [PRIO_W-1:0]  prio_mem [NUM_VOICES];

    // Result register
    logic    m_valid_reg, m_valid_next;
    result_t m_item_reg, res;

    logic                     accept, out_free, is_alloc, misc_en, commit;
    logic                     grant, do_grant;
    logic [IDX_W-1:0]         pick;
    logic signed [PRIO_W-1:0] eval_prio;
    logic                     eval_rsv, eval_act;
    logic                     sel_ok;
    logic [MAP_W-1:0]         map_full;

    // Fetch the control word for the current step
    always_comb begin
        uc = ucode_rom(upc_reg);
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_alloc = (item_reg.op == OP_ALLOC);

    // Next step: conditional jump or fall through
    always_comb begin
        case (uc.cond)
            C_NO_ACCEPT: jump = !accept;
            C_NOT_ALLOC: jump = !is_alloc;
            C_NOT_LAST:  jump = (pidx_reg != LAST_IDX);
            C_OUT_BUSY:  jump = !out_free;
            default:     jump = 1'b0;
        endcase
        upc_next = jump ? uc.target : step_t'(upc_reg + 2'd1);
    end

    // Control outputs and datapath decode
    always_comb begin
        s_ready   = uc.take;
        misc_en   = uc.misc && !is_alloc;
        commit    = uc.finish && out_free;

        // Voice under compare this cycle; an unwritten entry counts as priority zero
        eval_prio = rvld_reg ? rdata_reg : '0;
        eval_rsv  = (VOICE_W'(pidx_reg) == RSV_IDX);
        eval_act  = active_reg[pidx_reg];

        // A free voice always wins over a steal candidate
        grant     = free_found_reg || steal_found_reg;
        do_grant  = is_alloc && grant;
        pick      = free_found_reg ? free_idx_reg : steal_idx_reg;
        sel_ok    = ({1'b0, item_reg.voice_sel} < NV_LIM);
    end

    // Active map update: single-voice and bulk ops in dispatch, the grant in finish
    always_comb begin
        active_next = active_reg;
        if (misc_en) begin
            case (item_reg.op)
                OP_ACTIVATE: begin
                    if (sel_ok) active_next[item_reg.voice_sel[IDX_W-1:0]] = 1'b1;
                end
                OP_STOP: begin
                    if (sel_ok) active_next[item_reg.voice_sel[IDX_W-1:0]] = 1'b0;
                end
                OP_RETIRE:   active_next = active_reg & ~item_reg.ended_mask[NUM_VOICES-1:0];
                OP_STOP_ALL: active_next = '0;
                default:     active_next = active_reg;
            endcase
        end
        if (commit && do_grant) begin
            active_next[pick] = 1'b1;
        end
    end

    // Result assembled from the committed state
    always_comb begin
        map_full                   = '0;
        map_full[NUM_VOICES-1:0]   = active_next;
        res.granted                = do_grant;
        res.voice_out              = do_grant ? VOICE_W'(pick) : '0;
        res.stolen                 = do_grant && !free_found_reg;
        res.active_map             = map_full;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg         <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            active_reg      <= '0;
            pvld_reg        <= '0;
            free_found_reg  <= 1'b0;
            steal_found_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            m_valid_reg <= m_valid_next;
            active_reg  <= active_next;
            if (commit && do_grant) begin
                pvld_reg[pick] <= 1'b1;
            end
            if (accept) begin
                free_found_reg  <= 1'b0;
                steal_found_reg <= 1'b0;
            end else if (uc.scan && !eval_rsv) begin
                if (!eval_act && !free_found_reg) free_found_reg <= 1'b1;
                if (eval_prio < best_reg)         steal_found_reg <= 1'b1;
            end
        end
    end

    // Payload and scan datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
            idx_reg  <= '0;
            best_reg <= s_item.req_priority;
        end else begin
            if (uc.prime || (uc.scan && idx_reg != LAST_IDX)) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (uc.scan && !eval_rsv) begin
                if (!eval_act && !free_found_reg) free_idx_reg <= pidx_reg;
                if (eval_prio < best_reg) begin
                    best_reg      <= eval_prio;
                    steal_idx_reg <= pidx_reg;
                end
            end
        end
        // The read is registered, so it runs in the cycle before its compare
        pidx_reg <= idx_reg;
        rvld_reg <= pvld_reg[idx_reg];
        if (commit) begin
            m_item_reg <= res;
        end
    end

    // Priority memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (commit && do_grant) begin
            prio_mem[pick] <= item_reg.req_priority;
        end
        rdata_reg <= prio_mem[idx_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef ASSERT_OFF
    // An accepted transaction always moves the sequencer to dispatch
    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (upc_reg == ST_DISPATCH))
        else $error("sequencer did not dispatch after accept");

    // A steal is only ever reported alongside a grant
    a_stolen_granted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_item.stolen || m_item.granted))
        else $error("stolen without grant");

    // The granted voice is active in the reported map
    a_grant_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.granted) |-> m_item.active_map[m_item.voice_out])
        else $error("granted voice not active");

    // The reserved voice is never handed out
    a_no_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.granted) |-> (m_item.voice_out != RSV_IDX))
        else $error("reserved voice granted");
`endif

endmodule

// ===== test/vaps_voice_checker.sv =====
// Checker for the voice allocator: predicts each result and compares it with the output channel.
`timescale 1ns / 1ps

module vaps_voice_checker #(
    parameter int NUM_VOICES     = 32,
    parameter int RESERVED_VOICE = 31
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  vaps_pkg::item_t   s_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  vaps_pkg::result_t m_item,
    output int                fail_count,
    output int                outstanding
);
    import vaps_pkg::*;

    localparam logic [MAP_W-1:0] VOICE_MASK =
        (NUM_VOICES >= MAP_W) ? {MAP_W{1'b1}} : ((MAP_W'(1) << NUM_VOICES) - MAP_W'(1));
    localparam int REPORT_LIMIT = 10;

    logic [MAP_W-1:0]         voice_busy;
    logic signed [PRIO_W-1:0] voice_prio [NUM_VOICES];
    result_t                  predicted_outcomes [$];
    int                       mismatches;

    // Apply one event to the shadow voice table and return the outcome it produces.
    function automatic result_t apply_voice_event(input item_t ev);
        result_t                  res;
        logic signed [PRIO_W-1:0] lowest;
        bit                       found;
        int                       pick;
        res   = '0;
        found = 1'b0;
        pick  = 0;
        case (ev.op)
            OP_ALLOC: begin
                // free voice first, lowest index wins
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (!found && v != RESERVED_VOICE && !voice_busy[v]) begin
                        pick  = v;
                        found = 1'b1;
                    end
                end
                // otherwise steal: strictly below the request and every earlier candidate
                if (!found) begin
                    lowest = ev.req_priority;
                    for (int v = 0; v < NUM_VOICES; v++) begin
                        if (v != RESERVED_VOICE && voice_prio[v] < lowest) begin
                            lowest      = voice_prio[v];
                            pick        = v;
                            found       = 1'b1;
                            res.stolen  = 1'b1;
                        end
                    end
                end
                if (found) begin
                    res.granted     = 1'b1;
                    res.voice_out   = pick[VOICE_W-1:0];
                    voice_busy[pick] = 1'b1;
                    voice_prio[pick] = ev.req_priority;
                end
            end
            OP_ACTIVATE: begin
                if (ev.voice_sel < NUM_VOICES) voice_busy[ev.voice_sel] = 1'b1;
            end
            OP_STOP: begin
                if (ev.voice_sel < NUM_VOICES) voice_busy[ev.voice_sel] = 1'b0;
            end
            OP_RETIRE:   voice_busy = voice_busy & ~ev.ended_mask;
            OP_STOP_ALL: voice_busy = '0;
            default: ;
        endcase
        voice_busy     = voice_busy & VOICE_MASK;
        res.active_map = voice_busy;
        return res;
    endfunction

    task automatic flag_mismatch(input string why, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display({"%s: expected granted=%0b voice=%0d stolen=%0b map=%h, ",
                      "got granted=%0b voice=%0d stolen=%0b map=%h"},
                     why, want.granted, want.voice_out, want.stolen, want.active_map,
                     got.granted, got.voice_out, got.stolen, got.active_map);
    endtask

    always @(posedge aclk) begin : watch_channels
        result_t want;
        if (!aresetn) begin
            voice_busy = '0;
            for (int v = 0; v < NUM_VOICES; v++) voice_prio[v] = '0;
            predicted_outcomes.delete();
            mismatches = 0;
            outstanding <= 0;
            fail_count  <= 0;
        end else begin
            // results can never leave in the cycle their transaction arrives, so check first
            if (m_valid && m_ready) begin
                if (predicted_outcomes.size() == 0) begin
                    flag_mismatch("allocator result with nothing predicted", '0, m_item);
                end else begin
                    want = predicted_outcomes.pop_front();
                    if (m_item.granted !== want.granted || m_item.voice_out !== want.voice_out ||
                        m_item.stolen !== want.stolen || m_item.active_map !== want.active_map)
                        flag_mismatch("allocator result mismatch", want, m_item);
                end
            end
            if (s_valid && s_ready) predicted_outcomes.push_back(apply_voice_event(s_item));
            outstanding <= predicted_outcomes.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ===== test/tb_voice_allocator_priority_steal_unit.sv =====
// Testbench top for the voice allocator: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_voice_allocator_priority_steal_unit;
    import vaps_pkg::*;

    localparam int NUM_VOICES     = 32;
    localparam int RESERVED_VOICE = 31;
    localparam int ITEM_TARGET    = 550;
    // Slowest legal gap between transactions is an allocate scan plus the longest
    // receiver stall and sender gap; allow many times that.
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 60;
    // op codes with no meaning in the block; it must pass them through as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    item_t   s_item  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_item;

    int fail_count;
    int outstanding;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    rx_mode_t rx_mode       = RX_OPEN;
    int       rx_phase_left = 0;
    int       rx_stall_left = 0;

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    voice_allocator_priority_steal_unit #(
        .NUM_VOICES     (NUM_VOICES),
        .RESERVED_VOICE (RESERVED_VOICE)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    vaps_voice_checker #(
        .NUM_VOICES     (NUM_VOICES),
        .RESERVED_VOICE (RESERVED_VOICE)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Receiver: pick a new stall pattern whenever the current phase runs out, so
    // that results sometimes drain freely and sometimes back up into the sequencer.
    always @(posedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode       <= rx_mode_t'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(20, 200);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                // long stalls broken by ready cycles
                if (rx_stall_left != 0) begin
                    m_ready       <= 1'b0;
                    rx_stall_left <= rx_stall_left - 1;
                end else begin
                    m_ready       <= 1'b1;
                    rx_stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0;
                end
            end
        endcase
    end

    // Count cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // Fill every field with noise; callers override what the op needs.
    function automatic item_t noise_item();
        item_t it;
        it.op           = OP_W'($urandom_range(0, 7));
        it.req_priority = PRIO_W'($urandom);
        it.voice_sel    = VOICE_W'($urandom);
        it.ended_mask   = $urandom;
        return it;
    endfunction

    // Mix extremes, near-ties around zero and full-range priorities so that
    // strict-below comparisons see equal values often.
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        logic signed [PRIO_W-1:0] p;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0:       p = 8'h80;
                    1:       p = 8'h81;
                    2:       p = 8'h7E;
                    default: p = 8'h7F;
                endcase
            end
            1: begin
                p = PRIO_W'($urandom_range(0, 6));
                p = p - 8'sd3;
            end
            default: p = PRIO_W'($urandom);
        endcase
        return p;
    endfunction

    function automatic item_t alloc_item(input logic signed [PRIO_W-1:0] prio);
        item_t it;
        it              = noise_item();
        it.op           = OP_ALLOC;
        it.req_priority = prio;
        return it;
    endfunction

    function automatic item_t voice_item(input logic [OP_W-1:0] op,
                                         input logic [VOICE_W-1:0] sel);
        item_t it;
        it           = noise_item();
        it.op        = op;
        it.voice_sel = sel;
        return it;
    endfunction

    function automatic item_t retire_item(input logic [MAP_W-1:0] mask);
        item_t it;
        it            = noise_item();
        it.op         = OP_RETIRE;
        it.ended_mask = mask;
        return it;
    endfunction

    // Weighted single event: allocates most often, with enough stops and retires
    // to open holes but rarely clearing the whole map.
    function automatic item_t mixed_item();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it = alloc_item(pick_priority());
        else if (pick < 65)
            it = voice_item(OP_ACTIVATE, VOICE_W'($urandom));
        else if (pick < 78)
            it = voice_item(OP_STOP, VOICE_W'($urandom));
        else if (pick < 88)
            it = retire_item(($urandom_range(0, 1) == 0) ? MAP_W'($urandom) :
                             ((MAP_W'(1) << $urandom_range(0, 31)) |
                              (MAP_W'(1) << $urandom_range(0, 31))));
        else if (pick < 94)
            it = voice_item(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), VOICE_W'($urandom));
        else
            it = voice_item(OP_STOP_ALL, VOICE_W'($urandom));
        return it;
    endfunction

    // Present one transaction and hold it until the block takes it. Valid is left
    // high so the next transaction can follow back to back.
    task automatic offer(input item_t it);
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Send in bursts; between bursts drop valid for a random gap, sometimes long
    // enough to span a whole allocate scan.
    task automatic send_item(input item_t it);
        offer(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat (($urandom_range(0, 2) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
        end
    endtask

    // Hold the sender until every predicted result has left the block.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic fill_run();
        if ($urandom_range(0, 1) == 0) send_item(voice_item(OP_STOP_ALL, VOICE_W'($urandom)));
        // enough allocates to occupy every free voice and then start stealing
        repeat ($urandom_range(NUM_VOICES - 1, NUM_VOICES + 8)) send_item(alloc_item(pick_priority()));
    endtask

    task automatic steal_run();
        repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 4) == 0)
                send_item(voice_item(OP_STOP, VOICE_W'($urandom)));
            else
                send_item(alloc_item(pick_priority()));
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: grants on an empty map, priority extremes, reserved voice,
        // redundant activate, stops, retire masks and unused op codes.
        send_item(alloc_item(8'h7F));
        send_item(alloc_item(8'h80));
        send_item(voice_item(OP_ACTIVATE, VOICE_W'(RESERVED_VOICE)));
        send_item(voice_item(OP_ACTIVATE, 5'd0));
        send_item(voice_item(OP_STOP, 5'd1));
        send_item(voice_item(OP_STOP, VOICE_W'(RESERVED_VOICE)));
        send_item(alloc_item(8'h00));
        send_item(retire_item(32'hFFFF_FFFF));
        send_item(voice_item(OP_ACTIVATE, 5'd5));
        send_item(voice_item(OP_ACTIVATE, 5'd0));
        send_item(retire_item(32'h0000_0000));
        send_item(retire_item(32'h0000_0020));
        for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
            send_item(voice_item(OP_W'(c), VOICE_W'($urandom)));
        send_item(alloc_item(8'hFF));
        send_item(alloc_item(8'h01));
        send_item(voice_item(OP_STOP_ALL, 5'd0));
        send_item(alloc_item(8'h81));
        hold_until_drained();

        // Random: full maps come first so stealing and refusals start at once.
        fill_run();
        send_item(alloc_item(8'h80));
        steal_run();
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1: fill_run();
                2, 3: steal_run();
                4: begin
                    if ($urandom_range(0, 2) == 0)
                        hold_until_drained();
                    else
                        send_item(mixed_item());
                end
                default: send_item(mixed_item());
            endcase
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
